### rtl/iwk_pkg.sv
// Package for the ISO week-of-date block: shared types, calendar tables and
// the reciprocal constants used for the divisions by constants. No dependencies.
`default_nettype none

package iwk_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int WEEK_W  = 6;

	// Biased year (year + 399) and its remainder modulo 400
	localparam int BY_W  = 15;
	localparam int R_W   = 9;
	localparam int DOY_W = 9;

	localparam logic [BY_W-1:0] YEAR_BIAS_M1 = BY_W'(399);

	// floor(x / 25) = (x * 1311) >> 15 for x below 1100
	localparam int DIV25_MUL = 1311;
	localparam int DIV25_SH  = 15;
	// floor(x / 7) = (x * 293) >> 11 for x below 500
	localparam int DIV7_MUL  = 293;
	localparam int DIV7_SH   = 11;

	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	typedef logic [2:0] weekday_t;
	localparam weekday_t WD_MON = 3'd0;
	localparam weekday_t WD_FRI = 3'd4;
	localparam weekday_t WD_SAT = 3'd5;
	localparam weekday_t WD_SUN = 3'd6;

	localparam logic [WEEK_W-1:0] WEEKS_LONG  = 6'd53;
	localparam logic [WEEK_W-1:0] WEEKS_SHORT = 6'd52;
	localparam logic [WEEK_W-1:0] WEEK_FIRST  = 6'd1;

	// January day on which week 1 starts, by weekday of January 1
	localparam logic signed [3:0] FIRST_WEEK_START [7] =
		'{4'sd1, 4'sd0, -4'sd1, -4'sd2, 4'sd4, 4'sd3, 4'sd2};
	// December day on which the last week ends, by weekday of December 31
	localparam logic [5:0] LAST_WEEK_END [7] =
		'{6'd30, 6'd29, 6'd28, 6'd34, 6'd33, 6'd32, 6'd31};
	// Days before each month in a common year, index 1..12
	localparam logic [DOY_W-1:0] DAYS_BEFORE [13] =
		'{9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		  9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	typedef struct packed {
		weekday_t          jan1;
		logic              leap_prev;
		logic              leap_cur;
		logic [DOY_W-1:0]  doy;
	} cal_t;

endpackage

`default_nettype wire

### rtl/iwk_year_reduce.sv
// First calculation stage: clamps the month and reduces the biased year
// (year + 399) modulo 400. Depends on iwk_pkg.
`default_nettype none

module iwk_year_reduce
	import iwk_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       valid_s1,
	input  wire date_t      date_s1,
	output logic            valid_s2,
	output date_t           date_s2,
	output logic [R_W-1:0]  rem_s2
);

	logic [BY_W-1:0]  by_year;
	logic [10:0]      by_hi;
	logic [21:0]      q_prod;
	logic [5:0]       q400;
	logic [BY_W-1:0]  rem_full;
	date_t            date_norm;

	// Biased year over 400: divide by 16 with a shift, then by 25 by reciprocal
	assign by_year  = BY_W'(date_s1.year) + YEAR_BIAS_M1;
	assign by_hi    = by_year[BY_W-1:4];
	assign q_prod   = 22'(by_hi) * 22'(DIV25_MUL);
	assign q400     = q_prod[DIV25_SH +: 6];
	assign rem_full = by_year - BY_W'(q400) * BY_W'(400);

	always_comb begin
		date_norm = date_s1;
		if (date_s1.month == '0) begin
			date_norm.month = MON_JAN;
		end else if (date_s1.month > MON_DEC) begin
			date_norm.month = MON_DEC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		date_s2 <= date_norm;
		rem_s2  <= rem_full[R_W-1:0];
	end

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> rem_s2 < R_W'(400))
		else $error("year remainder out of range");

endmodule

`default_nettype wire

### rtl/iwk_calendar.sv
// Second calculation stage: weekday of January 1, leap flags of this and the
// previous year, and day of year. Depends on iwk_pkg.
`default_nettype none

module iwk_calendar
	import iwk_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       valid_s2,
	input  wire date_t      date_s2,
	input  wire logic [R_W-1:0] rem_s2,
	output logic            valid_s3,
	output date_t           date_s3,
	output cal_t            cal_s3
);

	logic [1:0]        cent;
	logic [R_W-1:0]    day_sum;
	logic [17:0]       q7_prod;
	logic [6:0]        q7;
	logic [R_W-1:0]    wd_full;
	logic [R_W:0]      rem_next;
	logic              leap_prev;
	logic              leap_cur;
	logic [DOY_W-1:0]  doy;

	// Day count of the year before, modulo 7; whole 400-year cycles drop out
	assign cent    = (rem_s2 >= R_W'(300)) ? 2'd3 :
	                 (rem_s2 >= R_W'(200)) ? 2'd2 :
	                 (rem_s2 >= R_W'(100)) ? 2'd1 : 2'd0;
	assign day_sum = rem_s2 + R_W'(rem_s2 >> 2) - R_W'(cent);
	assign q7_prod = 18'(day_sum) * 18'(DIV7_MUL);
	assign q7      = q7_prod[DIV7_SH +: 7];
	assign wd_full = day_sum - R_W'(q7) * R_W'(7);

	assign leap_prev = (rem_s2[1:0] == 2'd0) &&
		!(rem_s2 == R_W'(100) || rem_s2 == R_W'(200) || rem_s2 == R_W'(300));
	assign rem_next  = (R_W+1)'(rem_s2) + (R_W+1)'(1);
	assign leap_cur  = (rem_next[1:0] == 2'd0) &&
		!(rem_next == 10'd100 || rem_next == 10'd200 || rem_next == 10'd300);

	assign doy = DAYS_BEFORE[date_s2.month] + DOY_W'(date_s2.day) +
		DOY_W'(date_s2.month > MON_FEB && leap_cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		date_s3           <= date_s2;
		cal_s3.jan1       <= wd_full[2:0];
		cal_s3.leap_prev  <= leap_prev;
		cal_s3.leap_cur   <= leap_cur;
		cal_s3.doy        <= doy;
	end

	a_jan1_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> cal_s3.jan1 <= WD_SUN)
		else $error("weekday of January 1 out of range");

	a_doy_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> cal_s3.doy <= DOY_W'(366))
		else $error("day of year out of range");

endmodule

`default_nettype wire

### rtl/iwk_week.sv
// Final stage: picks the week year and week number from the calendar facts
// and holds them in the result register. Depends on iwk_pkg.
`default_nettype none

module iwk_week
	import iwk_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid_s3,
	input  wire date_t       date_s3,
	input  wire cal_t        cal_s3,
	output logic             valid_s4,
	output logic [YEAR_W-1:0] week_year_s4,
	output logic [WEEK_W-1:0] week_number_s4
);

	logic signed [3:0]  wk_start;
	weekday_t           dec31;
	logic               early;
	logic               late;
	logic signed [9:0]  span;
	logic [8:0]         span_u;
	logic [17:0]        wk_prod;
	logic [WEEK_W-1:0]  wk_norm;
	logic [WEEK_W-1:0]  wk_prev;
	logic [YEAR_W-1:0]  wy_next;
	logic [WEEK_W-1:0]  wn_next;

	assign wk_start = FIRST_WEEK_START[cal_s3.jan1];
	assign dec31    = !cal_s3.leap_cur ? cal_s3.jan1 :
	                  (cal_s3.jan1 == WD_SUN) ? WD_MON : cal_s3.jan1 + 3'd1;

	assign early = (date_s3.month == MON_JAN) &&
		($signed({1'b0, date_s3.day}) < $signed({{2{wk_start[3]}}, wk_start}));
	assign late  = (date_s3.month == MON_DEC) &&
		(6'(date_s3.day) > LAST_WEEK_END[dec31]);

	// Previous year has 53 weeks when its December 31 is a Thursday,
	// or a Friday in a leap year
	assign wk_prev = (cal_s3.jan1 == WD_FRI ||
		(cal_s3.jan1 == WD_SAT && cal_s3.leap_prev)) ? WEEKS_LONG : WEEKS_SHORT;

	assign span    = $signed({1'b0, cal_s3.doy}) - $signed({{6{wk_start[3]}}, wk_start});
	assign span_u  = span[8:0];
	assign wk_prod = 18'(span_u) * 18'(DIV7_MUL);
	assign wk_norm = WEEK_W'(wk_prod[DIV7_SH +: 7]) + WEEK_FIRST;

	always_comb begin
		if (early) begin
			wy_next = date_s3.year - YEAR_W'(1);
			wn_next = wk_prev;
		end else if (late) begin
			wy_next = date_s3.year + YEAR_W'(1);
			wn_next = WEEK_FIRST;
		end else begin
			wy_next = date_s3.year;
			wn_next = wk_norm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		week_year_s4   <= wy_next;
		week_number_s4 <= wn_next;
	end

	a_week_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (week_number_s4 >= WEEK_FIRST && week_number_s4 <= WEEKS_LONG))
		else $error("week number out of range");

	a_year_shift: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && (week_year_s4 != $past(date_s3.year)) |->
			(week_number_s4 == WEEK_FIRST || week_number_s4 == WEEKS_SHORT ||
			 week_number_s4 == WEEKS_LONG))
		else $error("week year moved outside a boundary week");

endmodule

`default_nettype wire

### rtl/iso_week_of_date.sv
// Top level of the ISO 8601 week-of-date block: input register and the three
// calculation stages. Depends on iwk_pkg, iwk_year_reduce, iwk_calendar, iwk_week.
//
// Give a Gregorian date on year, month and day with start high; the date is
// taken at that clock edge, and busy never rises, so a new date may be
// offered in every cycle. When the date has passed through the register
// ranks below, done is high for exactly one cycle with the ISO week-numbering
// year on week_year and the week (1 to 53, Monday start) on week_number; there
// is no way to hold a result off, so capture it while done is high. Results
// leave in the order the dates came in, one per cycle at most. There are four
// register ranks: the input register, the year-modulo-400 stage, the weekday
// and day-of-year stage, and the result register. Month zero counts as January
// and months above twelve as December; week_year wraps in 14 bits.
`default_nettype none

module iso_week_of_date
	import iwk_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [YEAR_W-1:0]  year,
	input  wire logic [MONTH_W-1:0] month,
	input  wire logic [DAY_W-1:0]   day,
	output logic                    done,
	output logic [YEAR_W-1:0]       week_year,
	output logic [WEEK_W-1:0]       week_number
);

	logic            valid_s1;
	date_t           date_s1;
	logic            valid_s2;
	date_t           date_s2;
	logic [R_W-1:0]  rem_s2;
	logic            valid_s3;
	date_t           date_s3;
	cal_t            cal_s3;

	// Every stage advances each cycle, so a beat is never refused
	assign busy = 1'b0;

	// Input register: hold the accepted beat for the first stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		date_s1.year  <= year;
		date_s1.month <= month;
		date_s1.day   <= day;
	end

	// Reduce the year modulo 400 and clamp the month
	iwk_year_reduce u_year_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.date_s1  (date_s1),
		.valid_s2 (valid_s2),
		.date_s2  (date_s2),
		.rem_s2   (rem_s2)
	);

	// Work out the weekday of January 1, the leap flags and the day of year
	iwk_calendar u_calendar (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.date_s2  (date_s2),
		.rem_s2   (rem_s2),
		.valid_s3 (valid_s3),
		.date_s3  (date_s3),
		.cal_s3   (cal_s3)
	);

	// Resolve the year boundaries and register the result beat
	iwk_week u_week (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s3       (valid_s3),
		.date_s3        (date_s3),
		.cal_s3         (cal_s3),
		.valid_s4       (done),
		.week_year_s4   (week_year),
		.week_number_s4 (week_number)
	);

endmodule

`default_nettype wire
